[src/drsc_pkg.sv]
// shared constants, types and helpers of the diophantine range solution counter
package drsc_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int FIELD_W       = 32;
    localparam int IN_W          = (OPERAND_WIDTH < FIELD_W) ? OPERAND_WIDTH : FIELD_W;
    localparam int DATA_W        = 64;
    localparam int PROD_W        = 68;
    localparam int MUL_W         = PROD_W / 2;
    localparam int SHORT_LEN     = 32;
    localparam int LONG_LEN      = 64;
    localparam int CNT_W         = $clog2(LONG_LEN) + 1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLASS,
        ST_GO,
        ST_WAIT,
        ST_DONE
    } t_state;

    typedef enum logic [4:0] {
        STP_ZMUL,
        STP_DIV_CB,
        STP_DIV_CA,
        STP_EU,
        STP_CG,
        STP_AG,
        STP_BG,
        STP_SM,
        STP_CM,
        STP_PM,
        STP_X0,
        STP_AX,
        STP_Y0,
        STP_T1,
        STP_T2,
        STP_T3,
        STP_T4,
        STP_FIN,
        STP_END
    } t_step;

    typedef struct packed {
        t_step step;
        logic  load;
        logic  start;
        logic  finish;
        logic  post;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic rem_zero;
        logic a_zero;
        logic b_zero;
    } t_sts;

    // operand read as a two's complement value of IN_W low bits
    function automatic logic signed [DATA_W-1:0] sext_in(input logic [FIELD_W-1:0] v);
        logic [DATA_W-1:0] r;
        r = '0;
        for (int i = 0; i < DATA_W; i++) begin
            r[i] = (i < IN_W) ? v[i] : v[IN_W-1];
        end
        return r;
    endfunction

endpackage

[src/drsc_if.sv]
// item channels of the diophantine range solution counter
interface drsc_in_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [drsc_pkg::FIELD_W-1:0]     coef_a;
    logic signed [drsc_pkg::FIELD_W-1:0]     coef_b;
    logic signed [drsc_pkg::FIELD_W-1:0]     rhs;
    logic signed [drsc_pkg::FIELD_W-1:0]     x_low;
    logic signed [drsc_pkg::FIELD_W-1:0]     x_high;
    logic signed [drsc_pkg::FIELD_W-1:0]     y_low;
    logic signed [drsc_pkg::FIELD_W-1:0]     y_high;

    modport source (output valid, coef_a, coef_b, rhs, x_low, x_high, y_low, y_high,
                    input ready);
    modport sink   (input valid, coef_a, coef_b, rhs, x_low, x_high, y_low, y_high,
                    output ready);
endinterface

interface drsc_out_if;
    logic                          valid;
    logic                          ready;
    logic [drsc_pkg::DATA_W-1:0]   solution_count;

    modport source (output valid, solution_count, input ready);
    modport sink   (input valid, solution_count, output ready);
endinterface

[src/drsc_div.sv]
// shared restoring divider with a horner product of the quotient bits
module drsc_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic                                 i_long,
    input  logic signed [drsc_pkg::DATA_W-1:0]   i_num,
    input  logic signed [drsc_pkg::DATA_W-1:0]   i_den,
    input  logic signed [drsc_pkg::DATA_W-1:0]   i_mul,
    output logic                                 o_busy,
    output logic                                 o_done,
    output logic signed [drsc_pkg::DATA_W-1:0]   o_quo,
    output logic signed [drsc_pkg::DATA_W-1:0]   o_rem,
    output logic signed [drsc_pkg::DATA_W-1:0]   o_prod,
    output logic                                 o_num_neg,
    output logic                                 o_den_neg
);

    localparam int DW = drsc_pkg::DATA_W;

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic [drsc_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic [DW-1:0]                r_rem, n_rem;
    logic [DW-1:0]                r_qd, n_qd;
    logic [DW-1:0]                r_den, n_den;
    logic [DW-1:0]                r_acc, n_acc;
    logic [DW-1:0]                r_mul, n_mul;
    logic                         r_nneg, n_nneg;
    logic                         r_dneg, n_dneg;

    logic [DW-1:0] num_mag, den_mag;
    logic [DW:0]   rem2, rem_sub;
    logic          ge;

    assign num_mag = i_num[DW-1] ? DW'(-i_num) : DW'(i_num);
    assign den_mag = i_den[DW-1] ? DW'(-i_den) : DW'(i_den);
    assign rem2    = {r_rem, r_qd[DW-1]};
    assign rem_sub = rem2 - {1'b0, r_den};
    assign ge      = (rem2 >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_qd   = r_qd;
        n_den  = r_den;
        n_acc  = r_acc;
        n_mul  = r_mul;
        n_nneg = r_nneg;
        n_dneg = r_dneg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = i_long ? drsc_pkg::CNT_W'(drsc_pkg::LONG_LEN)
                            : drsc_pkg::CNT_W'(drsc_pkg::SHORT_LEN);
            n_rem  = '0;
            n_qd   = i_long ? num_mag : (num_mag << (DW - drsc_pkg::SHORT_LEN));
            n_den  = den_mag;
            n_acc  = '0;
            n_mul  = i_mul;
            n_nneg = i_num[DW-1];
            n_dneg = i_den[DW-1];
        end else if (r_busy) begin
            n_rem = ge ? rem_sub[DW-1:0] : rem2[DW-1:0];
            n_qd  = {r_qd[DW-2:0], ge};
            n_acc = {r_acc[DW-2:0], 1'b0} + (ge ? r_mul : '0);
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == drsc_pkg::CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_qd   <= n_qd;
        r_den  <= n_den;
        r_acc  <= n_acc;
        r_mul  <= n_mul;
        r_nneg <= n_nneg;
        r_dneg <= n_dneg;
    end

    assign o_busy    = r_busy;
    assign o_done    = r_done;
    assign o_quo     = (r_nneg ^ r_dneg) ? -r_qd : r_qd;
    assign o_rem     = r_nneg ? -r_rem : r_rem;
    assign o_prod    = r_acc;
    assign o_num_neg = r_nneg;
    assign o_den_neg = r_dneg;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider restarted while busy");
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (i_den != '0)) else $error("divider started with zero divisor");
    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0)) else $error("divider busy with empty count");

endmodule

[src/drsc_dp.sv]
// datapath: operand registers, shared divider, multiplier and result register
module drsc_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  drsc_pkg::t_cmd                       i_cmd,
    output drsc_pkg::t_sts                       o_sts,
    input  logic [drsc_pkg::FIELD_W-1:0]         i_coef_a,
    input  logic [drsc_pkg::FIELD_W-1:0]         i_coef_b,
    input  logic [drsc_pkg::FIELD_W-1:0]         i_rhs,
    input  logic [drsc_pkg::FIELD_W-1:0]         i_x_low,
    input  logic [drsc_pkg::FIELD_W-1:0]         i_x_high,
    input  logic [drsc_pkg::FIELD_W-1:0]         i_y_low,
    input  logic [drsc_pkg::FIELD_W-1:0]         i_y_high,
    output logic [drsc_pkg::DATA_W-1:0]          o_count
);

    localparam int DW = drsc_pkg::DATA_W;
    localparam int MW = drsc_pkg::MUL_W;
    localparam int PW = drsc_pkg::PROD_W;

    function automatic logic [DW-1:0] span64(input logic signed [DW-1:0] lo,
                                             input logic signed [DW-1:0] hi);
        logic [DW-1:0] d;
        d = DW'(hi - lo) + DW'(1);
        return (hi < lo) ? '0 : d;
    endfunction

    logic signed [DW-1:0] r_a, r_b, r_c, r_x1, r_x2, r_y1, r_y2;
    logic [DW-1:0]        r_nx, r_ny;
    logic signed [DW-1:0] r_r0, r_r1, r_s0, r_s1;
    logic signed [DW-1:0] r_cg, r_s, r_ra, r_rb, r_mb, r_sm, r_cm, r_x0, r_y0;
    logic signed [DW-1:0] r_l1, r_h1, r_l2, r_h2;
    logic signed [PW-1:0] r_prod;
    logic [DW-1:0]        r_count, r_out_count;

    logic signed [DW-1:0] ld_a, ld_b, ld_c, ld_x1, ld_x2, ld_y1, ld_y2;
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [PW-1:0] mul_p;
    logic signed [DW-1:0] div_num, div_den, div_mul;
    logic                 div_long, div_start, mul_step;
    logic                 div_busy, div_done, div_nneg, div_dneg;
    logic signed [DW-1:0] div_quo, div_rem, div_prod;
    logic                 rem_nz, q_ceil_up, q_floor_dn;
    logic signed [DW-1:0] q_ceil, q_floor, rem_mod;
    logic signed [DW-1:0] fin_lo, fin_hi;
    logic [DW-1:0]        zsat;

    assign ld_a  = drsc_pkg::sext_in(i_coef_a);
    assign ld_b  = drsc_pkg::sext_in(i_coef_b);
    assign ld_c  = drsc_pkg::sext_in(i_rhs);
    assign ld_x1 = drsc_pkg::sext_in(i_x_low);
    assign ld_x2 = drsc_pkg::sext_in(i_x_high);
    assign ld_y1 = drsc_pkg::sext_in(i_y_low);
    assign ld_y2 = drsc_pkg::sext_in(i_y_high);

    // multiplier operands
    always_comb begin
        mul_step = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        case (i_cmd.step)
            drsc_pkg::STP_ZMUL: begin
                mul_step = 1'b1;
                mul_a    = MW'(r_nx);
                mul_b    = MW'(r_ny);
            end
            drsc_pkg::STP_PM: begin
                mul_step = 1'b1;
                mul_a    = MW'(r_sm);
                mul_b    = MW'(r_cm);
            end
            drsc_pkg::STP_AX: begin
                mul_step = 1'b1;
                mul_a    = MW'(r_a);
                mul_b    = MW'(r_x0);
            end
            default: begin
                mul_step = 1'b0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // divider operands
    always_comb begin
        div_num  = '0;
        div_den  = DW'(1);
        div_mul  = '0;
        div_long = 1'b0;
        case (i_cmd.step)
            drsc_pkg::STP_DIV_CB: begin
                div_num = r_c;
                div_den = r_b;
            end
            drsc_pkg::STP_DIV_CA: begin
                div_num = r_c;
                div_den = r_a;
            end
            drsc_pkg::STP_EU: begin
                div_num = r_r0;
                div_den = r_r1;
                div_mul = r_s1;
            end
            drsc_pkg::STP_CG: begin
                div_num = r_c;
                div_den = r_r0;
            end
            drsc_pkg::STP_AG: begin
                div_num = r_a;
                div_den = r_r0;
            end
            drsc_pkg::STP_BG: begin
                div_num = r_b;
                div_den = r_r0;
            end
            drsc_pkg::STP_SM: begin
                div_num = r_s;
                div_den = r_mb;
            end
            drsc_pkg::STP_CM: begin
                div_num = r_cg;
                div_den = r_mb;
            end
            drsc_pkg::STP_X0: begin
                div_num  = DW'(r_prod);
                div_den  = r_mb;
                div_long = 1'b1;
            end
            drsc_pkg::STP_Y0: begin
                div_num  = r_c - DW'(r_prod);
                div_den  = r_b;
                div_long = 1'b1;
            end
            drsc_pkg::STP_T1: begin
                div_num = r_rb[DW-1] ? (r_x2 - r_x0) : (r_x1 - r_x0);
                div_den = r_rb;
            end
            drsc_pkg::STP_T2: begin
                div_num = r_rb[DW-1] ? (r_x1 - r_x0) : (r_x2 - r_x0);
                div_den = r_rb;
            end
            drsc_pkg::STP_T3: begin
                div_num  = r_ra[DW-1] ? (r_y1 - r_y0) : (r_y2 - r_y0);
                div_den  = -r_ra;
                div_long = 1'b1;
            end
            drsc_pkg::STP_T4: begin
                div_num  = r_ra[DW-1] ? (r_y2 - r_y0) : (r_y1 - r_y0);
                div_den  = -r_ra;
                div_long = 1'b1;
            end
            default: begin
                div_long = 1'b0;
            end
        endcase
    end

    // the final interval step uses neither unit
    assign div_start = i_cmd.start && !mul_step && (i_cmd.step != drsc_pkg::STP_FIN);

    drsc_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_long    (div_long),
        .i_num     (div_num),
        .i_den     (div_den),
        .i_mul     (div_mul),
        .o_busy    (div_busy),
        .o_done    (div_done),
        .o_quo     (div_quo),
        .o_rem     (div_rem),
        .o_prod    (div_prod),
        .o_num_neg (div_nneg),
        .o_den_neg (div_dneg)
    );

    // floor and ceiling from the truncated quotient
    assign rem_nz     = (div_rem != '0);
    assign q_ceil_up  = rem_nz && (div_nneg == div_dneg);
    assign q_floor_dn = rem_nz && (div_nneg != div_dneg);
    assign q_ceil     = div_quo + DW'(q_ceil_up);
    assign q_floor    = div_quo - DW'(q_floor_dn);
    assign rem_mod    = div_rem[DW-1] ? (div_rem + r_mb) : div_rem;

    assign fin_lo = (r_l1 > r_l2) ? r_l1 : r_l2;
    assign fin_hi = (r_h1 < r_h2) ? r_h1 : r_h2;
    assign zsat   = (r_prod[PW-1:DW] != '0) ? '1 : r_prod[DW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a  <= ld_a;
            r_b  <= ld_b;
            r_c  <= ld_c;
            r_x1 <= ld_x1;
            r_x2 <= ld_x2;
            r_y1 <= ld_y1;
            r_y2 <= ld_y2;
            r_nx <= span64(ld_x1, ld_x2);
            r_ny <= span64(ld_y1, ld_y2);
            r_r0 <= ld_a[DW-1] ? -ld_a : ld_a;
            r_r1 <= ld_b[DW-1] ? -ld_b : ld_b;
            r_s0 <= DW'(1);
            r_s1 <= '0;
        end
        if (i_cmd.start && mul_step) begin
            r_prod <= mul_p;
        end
        if (i_cmd.finish) begin
            case (i_cmd.step)
                drsc_pkg::STP_ZMUL: begin
                    r_count <= (r_c == '0) ? zsat : '0;
                end
                drsc_pkg::STP_DIV_CB: begin
                    r_count <= (!rem_nz && div_quo >= r_y1 && div_quo <= r_y2) ? r_nx : '0;
                end
                drsc_pkg::STP_DIV_CA: begin
                    r_count <= (!rem_nz && div_quo >= r_x1 && div_quo <= r_x2) ? r_ny : '0;
                end
                drsc_pkg::STP_EU: begin
                    r_r0 <= r_r1;
                    r_r1 <= div_rem;
                    r_s0 <= r_s1;
                    r_s1 <= r_s0 - div_prod;
                end
                drsc_pkg::STP_CG: begin
                    r_cg <= div_quo;
                    r_s  <= r_a[DW-1] ? -r_s0 : r_s0;
                    if (rem_nz) begin
                        r_count <= '0;
                    end
                end
                drsc_pkg::STP_AG: begin
                    r_ra <= div_quo;
                end
                drsc_pkg::STP_BG: begin
                    r_rb <= div_quo;
                    r_mb <= div_quo[DW-1] ? -div_quo : div_quo;
                end
                drsc_pkg::STP_SM: begin
                    r_sm <= rem_mod;
                end
                drsc_pkg::STP_CM: begin
                    r_cm <= rem_mod;
                end
                drsc_pkg::STP_X0: begin
                    r_x0 <= div_rem;
                end
                drsc_pkg::STP_Y0: begin
                    r_y0 <= div_quo;
                end
                drsc_pkg::STP_T1: begin
                    r_l1 <= q_ceil;
                end
                drsc_pkg::STP_T2: begin
                    r_h1 <= q_floor;
                end
                drsc_pkg::STP_T3: begin
                    r_l2 <= q_ceil;
                end
                drsc_pkg::STP_T4: begin
                    r_h2 <= q_floor;
                end
                drsc_pkg::STP_FIN: begin
                    r_count <= span64(fin_lo, fin_hi);
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
        if (i_cmd.post) begin
            r_out_count <= r_count;
        end
    end

    assign o_sts.div_busy = div_busy;
    assign o_sts.div_done = div_done;
    assign o_sts.rem_zero = !rem_nz;
    assign o_sts.a_zero   = (r_a == '0);
    assign o_sts.b_zero   = (r_b == '0);
    assign o_count        = r_out_count;

endmodule

[src/drsc_ctrl.sv]
// controller: sequences the solve steps and runs both handshakes
module drsc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output drsc_pkg::t_cmd   o_cmd,
    input  drsc_pkg::t_sts   i_sts
);

    function automatic logic is_div_step(input drsc_pkg::t_step s);
        case (s)
            drsc_pkg::STP_ZMUL, drsc_pkg::STP_PM,
            drsc_pkg::STP_AX, drsc_pkg::STP_FIN: return 1'b0;
            default:                             return 1'b1;
        endcase
    endfunction

    drsc_pkg::t_state r_state, n_state;
    drsc_pkg::t_step  r_step, n_step, nxt;
    logic             r_out_valid, n_out_valid;

    // successor of the current step
    always_comb begin
        case (r_step)
            drsc_pkg::STP_EU: nxt = i_sts.rem_zero ? drsc_pkg::STP_CG : drsc_pkg::STP_EU;
            drsc_pkg::STP_CG: nxt = i_sts.rem_zero ? drsc_pkg::STP_AG : drsc_pkg::STP_END;
            drsc_pkg::STP_AG: nxt = drsc_pkg::STP_BG;
            drsc_pkg::STP_BG: nxt = drsc_pkg::STP_SM;
            drsc_pkg::STP_SM: nxt = drsc_pkg::STP_CM;
            drsc_pkg::STP_CM: nxt = drsc_pkg::STP_PM;
            drsc_pkg::STP_PM: nxt = drsc_pkg::STP_X0;
            drsc_pkg::STP_X0: nxt = drsc_pkg::STP_AX;
            drsc_pkg::STP_AX: nxt = drsc_pkg::STP_Y0;
            drsc_pkg::STP_Y0: nxt = drsc_pkg::STP_T1;
            drsc_pkg::STP_T1: nxt = drsc_pkg::STP_T2;
            drsc_pkg::STP_T2: nxt = drsc_pkg::STP_T3;
            drsc_pkg::STP_T3: nxt = drsc_pkg::STP_T4;
            drsc_pkg::STP_T4: nxt = drsc_pkg::STP_FIN;
            default:          nxt = drsc_pkg::STP_END;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        o_cmd        = '0;
        o_cmd.step   = r_step;
        o_in_ready   = 1'b0;
        case (r_state)
            drsc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = drsc_pkg::ST_CLASS;
                end
            end
            drsc_pkg::ST_CLASS: begin
                if (i_sts.a_zero && i_sts.b_zero) begin
                    n_step = drsc_pkg::STP_ZMUL;
                end else if (i_sts.a_zero) begin
                    n_step = drsc_pkg::STP_DIV_CB;
                end else if (i_sts.b_zero) begin
                    n_step = drsc_pkg::STP_DIV_CA;
                end else begin
                    n_step = drsc_pkg::STP_EU;
                end
                n_state = drsc_pkg::ST_GO;
            end
            drsc_pkg::ST_GO: begin
                o_cmd.start = 1'b1;
                n_state     = drsc_pkg::ST_WAIT;
            end
            drsc_pkg::ST_WAIT: begin
                if (!is_div_step(r_step) || i_sts.div_done) begin
                    o_cmd.finish = 1'b1;
                    if (nxt == drsc_pkg::STP_END) begin
                        n_state = drsc_pkg::ST_DONE;
                    end else begin
                        n_step  = nxt;
                        n_state = drsc_pkg::ST_GO;
                    end
                end
            end
            drsc_pkg::ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.post = 1'b1;
                    n_state    = drsc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = drsc_pkg::ST_IDLE;
            end
        endcase
        n_out_valid = o_cmd.post ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= drsc_pkg::ST_IDLE;
            r_step      <= drsc_pkg::STP_END;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == drsc_pkg::ST_WAIT))
        else $error("divider finished outside a wait");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == drsc_pkg::ST_IDLE) |-> !i_sts.div_busy)
        else $error("divider busy while idle");

endmodule

[src/diophantine_range_solution_count.sv]
// top level: counts integer solutions of a*x + b*y = c inside x and y bounds
//
//   channel   dir   handshake      payload
//   i_in      in    valid/ready    coef_a coef_b rhs x_low x_high y_low y_high (32b signed)
//   o_out     out   valid/ready    solution_count (64b unsigned, saturating)
//
// one item at a time; both coefficients zero take one multiply from accept to
// result, one coefficient zero takes one short division
// the general case runs extended euclid on the shared divider, one division per
// quotient step (up to about 46 steps), then seven short and four long
// divisions and two multiplies; a finished count sits in the output register,
// so the next item is taken while the result waits; synchronous active-low
// reset clears control only
module diophantine_range_solution_count (
    input  logic        i_clk,
    input  logic        i_rst_n,
    drsc_in_if.sink     i_in,
    drsc_out_if.source  o_out
);

    drsc_pkg::t_cmd cmd;
    drsc_pkg::t_sts sts;

    // sequencer: load, classify, then step through the divider and multiplier
    drsc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // operand registers, shared divider, multiplier and output count
    drsc_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .i_coef_a (i_in.coef_a),
        .i_coef_b (i_in.coef_b),
        .i_rhs    (i_in.rhs),
        .i_x_low  (i_in.x_low),
        .i_x_high (i_in.x_high),
        .i_y_low  (i_in.y_low),
        .i_y_high (i_in.y_high),
        .o_count  (o_out.solution_count)
    );

endmodule

[tb/sv/tb_diophantine_range_solution_count.sv]
// testbench of the diophantine range solution counter: directed and random items
module tb_diophantine_range_solution_count;

    typedef struct {
        logic signed [drsc_pkg::FIELD_W-1:0] coef_a;
        logic signed [drsc_pkg::FIELD_W-1:0] coef_b;
        logic signed [drsc_pkg::FIELD_W-1:0] rhs;
        logic signed [drsc_pkg::FIELD_W-1:0] x_low;
        logic signed [drsc_pkg::FIELD_W-1:0] x_high;
        logic signed [drsc_pkg::FIELD_W-1:0] y_low;
        logic signed [drsc_pkg::FIELD_W-1:0] y_high;
    } t_item;

    localparam logic [drsc_pkg::DATA_W-1:0] COUNT_MAX = '1;

    logic i_clk;
    logic i_rst_n;

    drsc_in_if  in_ch ();
    drsc_out_if out_ch ();

    diophantine_range_solution_count u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    logic [drsc_pkg::DATA_W-1:0] count_queue[$];
    int                n_errors;
    int                n_items;
    int                n_results;
    int                burst_left;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit: far above the run time of about 300 items plus idling
    initial begin
        #10_000_000;
        $display("timeout after %0d items, %0d results", n_items, n_results);
        $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // operand as a signed value of the low IN_W bits
    function automatic longint widen(logic [drsc_pkg::FIELD_W-1:0] v);
        longint r;
        r = longint'(signed'(v));
        return (r <<< (64 - drsc_pkg::IN_W)) >>> (64 - drsc_pkg::IN_W);
    endfunction

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && ((n < 0) != (d < 0))) q--;
        return q;
    endfunction

    function automatic longint ceil_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && ((n < 0) == (d < 0))) q++;
        return q;
    endfunction

    function automatic longint pos_mod(longint v, longint m);
        longint r;
        r = v % m;
        if (r < 0) r += m;
        return r;
    endfunction

    function automatic logic [drsc_pkg::DATA_W-1:0] range_size(longint lo, longint hi);
        if (hi < lo) return '0;
        return drsc_pkg::DATA_W'(hi - lo) + 1;
    endfunction

    // t interval with lo <= base + step*t <= hi
    function automatic void param_bounds(longint base, longint lo, longint hi,
                                         longint step, output longint tl,
                                         output longint th);
        if (step > 0) begin
            tl = ceil_div(lo - base, step);
            th = floor_div(hi - base, step);
        end else begin
            tl = ceil_div(hi - base, step);
            th = floor_div(lo - base, step);
        end
    endfunction

    function automatic logic [drsc_pkg::DATA_W-1:0] count_solutions(t_item it);
        longint a, b, c, xl, xh, yl, yh;
        longint r0, r1, s0, s1, k, tmp, g, ra, rb, mb, x0, y0;
        longint l1, h1, l2, h2;
        logic [drsc_pkg::DATA_W-1:0]   nx, ny;
        logic [2*drsc_pkg::DATA_W-1:0] prod;
        a  = widen(it.coef_a);
        b  = widen(it.coef_b);
        c  = widen(it.rhs);
        xl = widen(it.x_low);
        xh = widen(it.x_high);
        yl = widen(it.y_low);
        yh = widen(it.y_high);
        if (a == 0 && b == 0) begin
            if (c != 0) return '0;
            nx   = range_size(xl, xh);
            ny   = range_size(yl, yh);
            prod = nx * ny;
            return (prod > COUNT_MAX) ? COUNT_MAX : prod[drsc_pkg::DATA_W-1:0];
        end
        if (a == 0) begin
            if (c % b != 0 || c / b < yl || c / b > yh) return '0;
            return range_size(xl, xh);
        end
        if (b == 0) begin
            if (c % a != 0 || c / a < xl || c / a > xh) return '0;
            return range_size(yl, yh);
        end
        // extended euclid on the magnitudes, tracking the coefficient of |a|
        r0 = (a < 0) ? -a : a;
        r1 = (b < 0) ? -b : b;
        s0 = 1;
        s1 = 0;
        while (r1 != 0) begin
            k   = r0 / r1;
            tmp = r0 - k * r1;
            r0  = r1;
            r1  = tmp;
            tmp = s0 - k * s1;
            s0  = s1;
            s1  = tmp;
        end
        g = r0;
        if (c % g != 0) return '0;
        if (a < 0) s0 = -s0;
        ra = a / g;
        rb = b / g;
        mb = (rb < 0) ? -rb : rb;
        x0 = pos_mod(pos_mod(s0, mb) * pos_mod(c / g, mb), mb);
        y0 = (c - a * x0) / b;
        param_bounds(x0, xl, xh, rb, l1, h1);
        param_bounds(y0, yl, yh, -ra, l2, h2);
        return range_size((l1 > l2) ? l1 : l2, (h1 < h2) ? h1 : h2);
    endfunction

    // ---------------------------------------------------------------
    // result side: stall pattern and compare
    // ---------------------------------------------------------------

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    int stall_mode;
    int stall_tick;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall_tick   <= 0;
            stall_mode   <= 0;
        end else begin
            // stall behavior drawn at random from always ready, sparse or long stalls
            stall_tick <= stall_tick + 1;
            if (stall_tick % 40 == 0) stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: begin
                    out_ch.ready <= 1'b1;
                end
                1: begin
                    out_ch.ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    out_ch.ready <= ((stall_tick % 16) > 10);
                end
            endcase
            if (out_ch.valid && out_ch.ready) begin
                n_results++;
                if (count_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected count %0d",
                                              out_ch.solution_count));
                end else begin
                    if (out_ch.solution_count !== count_queue[0]) begin
                        report_mismatch($sformatf("solution_count %0d, expected %0d",
                                                  out_ch.solution_count, count_queue[0]));
                    end
                    void'(count_queue.pop_front());
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // item side
    // ---------------------------------------------------------------

    // drive one item and hold it until the block takes it
    task automatic send_item(t_item it);
        in_ch.valid  <= 1'b1;
        in_ch.coef_a <= it.coef_a;
        in_ch.coef_b <= it.coef_b;
        in_ch.rhs    <= it.rhs;
        in_ch.x_low  <= it.x_low;
        in_ch.x_high <= it.x_high;
        in_ch.y_low  <= it.y_low;
        in_ch.y_high <= it.y_high;
        do @(posedge i_clk); while (!in_ch.ready);
        count_queue.push_back(count_solutions(it));
        n_items++;
        // bursts of back-to-back items separated by random gaps
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 6);
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge i_clk);
        end
    endtask

    function automatic t_item make_item(int a, int b, int c, int xl, int xh,
                                        int yl, int yh);
        t_item it;
        it.coef_a = a;
        it.coef_b = b;
        it.rhs    = c;
        it.x_low  = xl;
        it.x_high = xh;
        it.y_low  = yl;
        it.y_high = yh;
        return it;
    endfunction

    localparam int SMIN = 32'sh8000_0000;
    localparam int SMAX = 32'sh7fff_ffff;

    task automatic test_degenerate();
        // both coefficients zero: full ranges saturate, single column, small product, no solution, empty range
        send_item(make_item(0, 0, 0, SMIN, SMAX, SMIN, SMAX));
        send_item(make_item(0, 0, 0, SMIN, SMAX, 5, 5));
        send_item(make_item(0, 0, 0, -3, 4, 10, 12));
        send_item(make_item(0, 0, 7, SMIN, SMAX, SMIN, SMAX));
        send_item(make_item(0, 0, 0, 4, 3, 0, 9));
        // one coefficient zero: exact and inexact division, in and out of bounds
        send_item(make_item(0, -3, 12, SMIN, SMAX, -4, -4));
        send_item(make_item(0, 5, 12, 0, 100, SMIN, SMAX));
        send_item(make_item(0, 2, 20, 0, 100, 11, 20));
        send_item(make_item(SMIN, 0, SMIN, -10, 10, SMIN, SMAX));
        send_item(make_item(7, 0, -21, -3, -3, 0, 9));
        send_item(make_item(-1, 0, SMIN, SMIN, SMAX, 2, 1));
    endtask

    task automatic test_general_extremes();
        send_item(make_item(1, 1, 0, SMIN, SMAX, SMIN, SMAX));
        send_item(make_item(SMIN, SMIN, SMIN, SMIN, SMAX, SMIN, SMAX));
        send_item(make_item(SMAX, SMIN, SMAX, SMIN, SMAX, SMIN, SMAX));
        send_item(make_item(-1, SMAX, SMIN, SMIN, SMAX, SMIN, SMAX));
        // consecutive fibonacci numbers: longest euclid chain
        send_item(make_item(1836311903, 1134903170, 1, SMIN, SMAX, SMIN, SMAX));
        send_item(make_item(-1134903170, 1836311903, -7, SMIN, SMAX, SMIN, SMAX));
        // gcd not dividing rhs, then a solvable case and empty bounds
        send_item(make_item(6, 10, 7, SMIN, SMAX, SMIN, SMAX));
        send_item(make_item(4, -6, 2, -100, 100, -100, 100));
        send_item(make_item(3, 5, 8, 5, -5, -10, 10));
        send_item(make_item(-3, -5, 1, -10, 10, 10, -10));
    endtask

    function automatic int rand_word();
        case ($urandom_range(0, 5))
            0:       return SMIN;
            1:       return SMAX;
            2:       return $urandom_range(0, 20) - 10;
            default: return $urandom;
        endcase
    endfunction

    function automatic int rand_small(int span_max);
        return int'($urandom_range(0, 2 * span_max)) - span_max;
    endfunction

    task automatic test_random(int count);
        t_item it;
        int a, b, x0, y0, w, xl, xh, yl, yh, tmp;
        repeat (count) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    // unconstrained noise from extremes, small values and random words
                    it = make_item(rand_word(), rand_word(), rand_word(), rand_word(),
                                   rand_word(), rand_word(), rand_word());
                end
                2: begin
                    a = ($urandom_range(0, 1) != 0) ? rand_small(50) : 0;
                    b = (a != 0 && $urandom_range(0, 1) != 0) ? 0 : rand_small(50);
                    x0 = rand_small(1000);
                    y0 = rand_small(1000);
                    it = make_item(a, b, ($urandom_range(0, 3) == 0) ? rand_word() : a * x0 + b * y0,
                                   x0 - rand_small(500), x0 + rand_small(500),
                                   y0 - rand_small(500), y0 + rand_small(500));
                end
                default: begin
                    // mostly solvable equation with bounds placed around a known solution
                    a  = rand_small(($urandom_range(0, 1) != 0) ? 32767 : 40);
                    b  = rand_small(($urandom_range(0, 1) != 0) ? 32767 : 40);
                    x0 = rand_small(32767);
                    y0 = rand_small(32767);
                    w  = ($urandom_range(0, 2) == 0) ? 100000 : $urandom_range(0, 3000);
                    xl = x0 - int'($urandom_range(0, w));
                    xh = x0 + int'($urandom_range(0, w));
                    yl = y0 - int'($urandom_range(0, w));
                    yh = y0 + int'($urandom_range(0, w));
                    if ($urandom_range(0, 15) == 0) begin
                        tmp = xl;
                        xl  = xh + 1;
                        xh  = tmp;
                    end
                    if ($urandom_range(0, 15) == 0) begin
                        xl = SMIN;
                        yh = SMAX;
                    end
                    it = make_item(a, b, a * x0 + b * y0 + (($urandom_range(0, 9) == 0) ? 1 : 0),
                                   xl, xh, yl, yh);
                end
            endcase
            send_item(it);
        end
    endtask

    initial begin
        n_errors     = 0;
        n_items      = 0;
        n_results    = 0;
        burst_left   = 0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.coef_a = '0;
        in_ch.coef_b = '0;
        in_ch.rhs    = '0;
        in_ch.x_low  = '0;
        in_ch.x_high = '0;
        in_ch.y_low  = '0;
        in_ch.y_high = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_degenerate();
        test_general_extremes();
        test_random(280);

        in_ch.valid <= 1'b0;
        while (count_queue.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("covered %0d items: zero coefficients, euclid extremes, empty bounds,",
                 n_items);
        $display("and random solvable and unsolvable equations; %0d counts checked",
                 n_results);
        if (n_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

[files.f]
src/drsc_pkg.sv
src/drsc_if.sv
src/drsc_div.sv
src/drsc_dp.sv
src/drsc_ctrl.sv
src/diophantine_range_solution_count.sv
tb/sv/tb_diophantine_range_solution_count.sv
